FILE: rtl/bbl_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bbl_pkg
// Shared types and constants of the box-blur line pass: pixel layout,
// sequencer states and the control word of the shared divider.
// ---------------------------------------------------------------------------
package bbl_pkg;

    // pixel layout
    localparam int unsigned PIX_W    = 8;
    localparam int unsigned CH_N     = 4;
    localparam int unsigned CH_W     = 2;
    localparam int unsigned PX_W     = PIX_W * CH_N;

    // configuration register width and default largest radius
    localparam int unsigned RADIUS_W       = 6;
    localparam int unsigned RADIUS_MAX_DEF = 63;
    localparam int unsigned RADIUS_RST     = 1;

    // channel slots in a packed pixel
    localparam logic [CH_W-1:0] CH_ALPHA = 2'd3;
    localparam logic [CH_W-1:0] CH_RED   = 2'd2;
    localparam logic [CH_W-1:0] CH_GREEN = 2'd1;
    localparam logic [CH_W-1:0] CH_BLUE  = 2'd0;

    typedef logic [CH_N-1:0][PIX_W-1:0] t_pix;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_UPD,
        S_DIV,
        S_DRAIN,
        S_PUSH
    } t_state;

    // divider issue / result tag
    typedef struct packed {
        logic            vld;
        logic [CH_W-1:0] ch;
    } t_div_ctl;

endpackage
`default_nettype wire

FILE: rtl/bbl_ifs.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bbl_in_if / bbl_out_if
// Valid/ready channels for incoming pixels and blurred result pixels.
// ---------------------------------------------------------------------------
interface bbl_in_if;
    logic                      valid;
    logic                      ready;
    logic [bbl_pkg::PIX_W-1:0] alpha_in;
    logic [bbl_pkg::PIX_W-1:0] red_in;
    logic [bbl_pkg::PIX_W-1:0] green_in;
    logic [bbl_pkg::PIX_W-1:0] blue_in;
    logic                      line_end;

    modport source (output valid, alpha_in, red_in, green_in, blue_in, line_end,
                    input ready);
    modport sink (input valid, alpha_in, red_in, green_in, blue_in, line_end,
                  output ready);
endinterface

interface bbl_out_if;
    logic                      valid;
    logic                      ready;
    logic [bbl_pkg::PIX_W-1:0] alpha_out;
    logic [bbl_pkg::PIX_W-1:0] red_out;
    logic [bbl_pkg::PIX_W-1:0] green_out;
    logic [bbl_pkg::PIX_W-1:0] blue_out;
    logic                      line_done;

    modport source (output valid, alpha_out, red_out, green_out, blue_out, line_done,
                    input ready);
    modport sink (input valid, alpha_out, red_out, green_out, blue_out, line_done,
                  output ready);
endinterface
`default_nettype wire

FILE: rtl/bbl_line_store.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bbl_line_store
// Circular pixel store of the current line: one write port, one read port
// with registered read data.
// ---------------------------------------------------------------------------
module bbl_line_store #(
    parameter int unsigned AW = 7
) (
    input  wire                       i_clk,
    input  wire                       i_we,
    input  wire  [AW-1:0]             i_waddr,
    input  wire  [bbl_pkg::PX_W-1:0]  i_wdata,
    input  wire  [AW-1:0]             i_raddr,
    output logic [bbl_pkg::PX_W-1:0]  o_rdata
);

    logic [bbl_pkg::PX_W-1:0] r_mem [2**AW];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

FILE: rtl/bbl_recip_div.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bbl_recip_div
// Shared divider: window sum divided by the odd window 2r+1 through a
// multiply by a rounded-up reciprocal and a shift. One channel per cycle,
// one register stage after the multiplier.
// ---------------------------------------------------------------------------
module bbl_recip_div #(
    parameter int unsigned RADIUS_MAX = bbl_pkg::RADIUS_MAX_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire  [$clog2(RADIUS_MAX+1)-1:0]     i_radius,
    input  bbl_pkg::t_div_ctl                   i_ctl,
    input  wire  [bbl_pkg::PIX_W+$clog2(RADIUS_MAX+1):0] i_sum,
    output bbl_pkg::t_div_ctl                   o_ctl,
    output logic [bbl_pkg::PIX_W-1:0]           o_quot
);

    localparam int unsigned RAD_W  = $clog2(RADIUS_MAX + 1);
    localparam int unsigned WIN_W  = RAD_W + 1;
    localparam int unsigned SUM_W  = bbl_pkg::PIX_W + WIN_W;
    // shift large enough that the reciprocal error stays below one LSB
    localparam int unsigned SHIFT  = SUM_W + WIN_W;
    localparam int unsigned RCP_W  = SHIFT + 1;
    localparam int unsigned PROD_W = SUM_W + RCP_W;

    logic [RCP_W-1:0]  w_rcp [RADIUS_MAX+1];
    logic [RCP_W-1:0]  r_rcp;
    logic [PROD_W-1:0] r_prod;
    bbl_pkg::t_div_ctl r_ctl;

    // reciprocal table: ceil(2^SHIFT / (2r+1)) for each radius
    for (genvar g = 0; g <= RADIUS_MAX; g++) begin : g_rcp
        localparam int unsigned DIVR = 2 * g + 1;
        localparam int unsigned RCP  = ((1 << SHIFT) + DIVR - 1) / DIVR;
        assign w_rcp[g] = RCP_W'(RCP);
    end

    // reciprocal of the line's window, stable for the whole line
    always_ff @(posedge i_clk) begin
        r_rcp <= w_rcp[i_radius];
    end

    // multiply stage
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_sum) * PROD_W'(r_rcp);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    // quotient always fits in a channel
    assign o_quot = r_prod[SHIFT +: bbl_pkg::PIX_W];
    assign o_ctl  = r_ctl;

endmodule
`default_nettype wire

FILE: rtl/box_blur_line_pass_top.sv
`default_nettype none
// An accepted pixel runs S_FETCH (store read) and S_UPD (sum update); if its line position has reached r,
// S_DIV then issues the four channels in turn to the one shared reciprocal divider,
// then S_DRAIN and S_PUSH, which loads the output register once it is free.
// A new pixel is taken only in S_IDLE, so each pixel is finished before the next
// is accepted. After the last pixel of a line, r flush steps repeat it through the same states; no input meanwhile.
// Reset: synchronous, active low; radius returns to 1, no line in progress.
// ---------------------------------------------------------------------------
// box_blur_line_pass_top
// One horizontal box-blur pass over a streamed line of ARGB pixels, with
// edge pixels repeated. Running window sums per channel are updated from a
// circular line store, and a small sequencer feeds them one channel a cycle
// to a shared reciprocal-multiply divider.
// ---------------------------------------------------------------------------
module box_blur_line_pass_top #(
    parameter int unsigned RADIUS_MAX = bbl_pkg::RADIUS_MAX_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    bbl_in_if.sink                         i_pix,
    bbl_out_if.source                      o_res,
    input  wire                            i_cfg_we,
    input  wire  [bbl_pkg::RADIUS_W-1:0]   i_cfg_radius
);

    localparam int unsigned RAD_W = $clog2(RADIUS_MAX + 1);
    localparam int unsigned WIN_W = RAD_W + 1;
    localparam int unsigned SUM_W = bbl_pkg::PIX_W + WIN_W;
    localparam int unsigned AW    = WIN_W;
    localparam int unsigned CH_N  = bbl_pkg::CH_N;

    // registers
    bbl_pkg::t_state                r_state, n_state;
    logic [bbl_pkg::RADIUS_W-1:0]   r_radius_cfg;
    logic [RAD_W-1:0]               r_radius;
    logic                           r_in_line;
    logic                           r_last;
    logic [AW-1:0]                  r_pos;
    logic [WIN_W-1:0]               r_j;
    logic [RAD_W-1:0]               r_flush_left;
    logic [bbl_pkg::CH_W-1:0]       r_ch;
    bbl_pkg::t_pix                  r_pix;
    bbl_pkg::t_pix                  r_first_pix;
    logic [SUM_W-1:0]               r_sum [CH_N];
    logic [SUM_W-1:0]               n_sum [CH_N];
    bbl_pkg::t_pix                  r_res;
    logic                           r_done;
    logic                           r_out_valid;
    bbl_pkg::t_pix                  r_out_pix;
    logic                           r_out_done;

    // combinational
    logic                           w_fire_in;
    logic                           w_fire_out;
    bbl_pkg::t_pix                  w_in_pix;
    logic [RAD_W-1:0]               w_cfg_sat;
    logic [WIN_W-1:0]               w_win;
    logic [AW-1:0]                  w_pos_inc;
    logic [AW-1:0]                  w_waddr;
    logic [AW-1:0]                  w_raddr;
    logic [WIN_W-1:0]               w_j_inc;
    logic [bbl_pkg::PX_W-1:0]       w_rdata;
    bbl_pkg::t_pix                  w_leave;
    logic                           w_emit;
    logic                           w_more;
    logic                           w_out_free;
    logic                           w_ready;
    logic                           w_issue;
    logic                           w_load;
    logic                           w_step;
    logic                           w_close;
    bbl_pkg::t_div_ctl              w_div_ctl;
    bbl_pkg::t_div_ctl              w_div_octl;
    logic [bbl_pkg::PIX_W-1:0]      w_quot;

    assign w_fire_in  = i_pix.valid & w_ready;
    assign w_fire_out = r_out_valid & o_res.ready;
    assign w_out_free = !r_out_valid || o_res.ready;

    assign w_in_pix[bbl_pkg::CH_ALPHA] = i_pix.alpha_in;
    assign w_in_pix[bbl_pkg::CH_RED]   = i_pix.red_in;
    assign w_in_pix[bbl_pkg::CH_GREEN] = i_pix.green_in;
    assign w_in_pix[bbl_pkg::CH_BLUE]  = i_pix.blue_in;

    // radius beyond the supported range saturates
    assign w_cfg_sat = (r_radius_cfg > bbl_pkg::RADIUS_W'(RADIUS_MAX)) ?
                       RAD_W'(RADIUS_MAX) : RAD_W'(r_radius_cfg);

    // window 2r+1 and store addressing
    assign w_win     = {r_radius, 1'b1};
    assign w_pos_inc = r_pos + 1'b1;
    assign w_waddr   = r_in_line ? w_pos_inc : '0;
    assign w_raddr   = r_pos - w_win;
    assign w_j_inc   = (&r_j) ? r_j : r_j + 1'b1;

    // leaving pixel: stored one if it lies inside the line, else the first
    assign w_leave = (r_j >= w_win) ? bbl_pkg::t_pix'(w_rdata) : r_first_pix;
    assign w_emit  = r_j >= {1'b0, r_radius};
    assign w_more  = r_last && (r_flush_left != '0);

    bbl_line_store #(
        .AW (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_fire_in),
        .i_waddr (w_waddr),
        .i_wdata (w_in_pix),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_div_ctl.vld = w_issue;
    assign w_div_ctl.ch  = r_ch;

    bbl_recip_div #(
        .RADIUS_MAX (RADIUS_MAX)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_radius (r_radius),
        .i_ctl    (w_div_ctl),
        .i_sum    (r_sum[r_ch]),
        .o_ctl    (w_div_octl),
        .o_quot   (w_quot)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bbl_pkg::S_IDLE: begin
                if (w_fire_in) n_state = bbl_pkg::S_FETCH;
            end
            bbl_pkg::S_FETCH: begin
                n_state = bbl_pkg::S_UPD;
            end
            bbl_pkg::S_UPD: begin
                if (w_emit)      n_state = bbl_pkg::S_DIV;
                else if (w_more) n_state = bbl_pkg::S_FETCH;
                else             n_state = bbl_pkg::S_IDLE;
            end
            bbl_pkg::S_DIV: begin
                if (r_ch == bbl_pkg::CH_W'(CH_N - 1)) n_state = bbl_pkg::S_DRAIN;
            end
            bbl_pkg::S_DRAIN: begin
                n_state = bbl_pkg::S_PUSH;
            end
            bbl_pkg::S_PUSH: begin
                if (w_out_free) n_state = w_more ? bbl_pkg::S_FETCH : bbl_pkg::S_IDLE;
            end
            default: n_state = bbl_pkg::S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        w_ready = 1'b0;
        w_issue = 1'b0;
        w_load  = 1'b0;
        unique case (r_state)
            bbl_pkg::S_IDLE:  w_ready = 1'b1;
            bbl_pkg::S_DIV:   w_issue = 1'b1;
            bbl_pkg::S_PUSH:  w_load  = w_out_free;
            bbl_pkg::S_FETCH,
            bbl_pkg::S_UPD,
            bbl_pkg::S_DRAIN: ;
            default: ;
        endcase
    end

    // a flush step follows, or the line closes after its final result
    assign w_step  = ((r_state == bbl_pkg::S_UPD && !w_emit) || w_load) && w_more;
    assign w_close = ((r_state == bbl_pkg::S_UPD && !w_emit) || w_load) && !w_more && r_last;

    // window sum update: fill with the first pixel, then add entering, drop leaving
    always_comb begin
        for (int k = 0; k < CH_N; k++) begin
            if (r_j == '0) begin
                n_sum[k] = SUM_W'(w_win) * SUM_W'(r_pix[k]);
            end else begin
                n_sum[k] = r_sum[k] + SUM_W'(r_pix[k]) - SUM_W'(w_leave[k]);
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= bbl_pkg::S_IDLE;
            r_radius_cfg <= bbl_pkg::RADIUS_W'(bbl_pkg::RADIUS_RST);
            r_radius     <= RAD_W'(bbl_pkg::RADIUS_RST);
            r_in_line    <= 1'b0;
            r_last       <= 1'b0;
            r_pos        <= '0;
            r_j          <= '0;
            r_flush_left <= '0;
            r_ch         <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_radius_cfg <= i_cfg_radius;
            end
            // pixel transfer: new line latches radius and restarts positions
            if (w_fire_in) begin
                r_last    <= i_pix.line_end;
                r_in_line <= 1'b1;
                r_pos     <= w_waddr;
                if (!r_in_line) begin
                    r_radius     <= w_cfg_sat;
                    r_j          <= '0;
                    r_flush_left <= i_pix.line_end ? w_cfg_sat : '0;
                end else begin
                    r_j          <= w_j_inc;
                    r_flush_left <= i_pix.line_end ? r_radius : '0;
                end
            end
            // flush step: last pixel enters again at a virtual position
            if (w_step) begin
                r_flush_left <= r_flush_left - 1'b1;
                r_pos        <= w_pos_inc;
                r_j          <= w_j_inc;
            end
            if (w_close) begin
                r_in_line <= 1'b0;
            end
            // channel counter for divider issue
            if (w_issue) begin
                r_ch <= r_ch + 1'b1;
            end
            // output register
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (w_fire_out) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_fire_in) begin
            r_pix <= w_in_pix;
            if (!r_in_line) begin
                r_first_pix <= w_in_pix;
            end
        end
        if (r_state == bbl_pkg::S_UPD) begin
            for (int k = 0; k < CH_N; k++) begin
                r_sum[k] <= n_sum[k];
            end
            r_done <= r_last && (r_flush_left == '0);
        end
        if (w_div_octl.vld) begin
            r_res[w_div_octl.ch] <= w_quot;
        end
        if (w_load) begin
            r_out_pix  <= r_res;
            r_out_done <= r_done;
        end
    end

    assign i_pix.ready     = w_ready;
    assign o_res.valid     = r_out_valid;
    assign o_res.alpha_out = r_out_pix[bbl_pkg::CH_ALPHA];
    assign o_res.red_out   = r_out_pix[bbl_pkg::CH_RED];
    assign o_res.green_out = r_out_pix[bbl_pkg::CH_GREEN];
    assign o_res.blue_out  = r_out_pix[bbl_pkg::CH_BLUE];
    assign o_res.line_done = r_out_done;

`ifndef SYNTH
    // flush steps only follow the last pixel of a line
    a_flush_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_flush_left != '0) |-> r_last)
        else $error("flush pending without last pixel");

    // store position tracks the line position until the latter saturates
    a_pos_tracks_j: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_j != '1) |-> (r_pos == r_j))
        else $error("store position out of step with line position");

    // alpha and blue divider results are the truncated quotients of their window sums
    a_quot_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bbl_pkg::S_PUSH) |->
        ((int'(r_res[bbl_pkg::CH_ALPHA]) * int'(w_win) <= int'(r_sum[bbl_pkg::CH_ALPHA])) &&
         (int'(r_sum[bbl_pkg::CH_ALPHA]) < (int'(r_res[bbl_pkg::CH_ALPHA]) + 1) * int'(w_win))))
        else $error("alpha quotient wrong");

    a_quot_blue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bbl_pkg::S_PUSH) |->
        ((int'(r_res[bbl_pkg::CH_BLUE]) * int'(w_win) <= int'(r_sum[bbl_pkg::CH_BLUE])) &&
         (int'(r_sum[bbl_pkg::CH_BLUE]) < (int'(r_res[bbl_pkg::CH_BLUE]) + 1) * int'(w_win))))
        else $error("blue quotient wrong");
`endif

endmodule
`default_nettype wire

FILE: sim/box_blur_line_pass_top_tb.sv
`default_nettype none
// ---------------------------------------------------------------------------
// box_blur_line_pass_top_tb
// Self-checking bench for the box-blur line pass. Pixel lines are queued by
// a stimulus process, pushed through a valid/ready driver, and every accepted
// pixel is run through a line-buffer predictor that computes the clamped-edge
// window means. A monitor with random stalls compares each blurred pixel
// against the oldest predicted one, field by field.
// ---------------------------------------------------------------------------
module box_blur_line_pass_top_tb;
    import bbl_pkg::*;

    localparam int DRAIN_CYCLES = 24;      // settle pause once all results are in
    localparam int HOLD_CYCLES  = 250;     // long receiver back-pressure
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 110;
    localparam int LONG_LINE    = 132;     // longer than the line store, forces wrap

    typedef struct packed {
        t_pix px;
        logic last;
    } t_pix_item;

    typedef struct packed {
        t_pix px;
        logic done;
    } t_blur_res;

    logic                clk;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [RADIUS_W-1:0] cfg_radius = '0;

    bbl_in_if  pix_if ();
    bbl_out_if res_if ();

    box_blur_line_pass_top dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_pix        (pix_if),
        .o_res        (res_if),
        .i_cfg_we     (cfg_we),
        .i_cfg_radius (cfg_radius)
    );

    // stimulus backlog and predicted blurred pixels
    t_pix_item pix_backlog [$];
    t_blur_res pending_blurs [$];

    // predictor state: configured radius, radius latched for the line, line pixels
    logic [RADIUS_W-1:0] radius_shadow = RADIUS_RST;
    int                  line_r = RADIUS_RST;
    t_pix                line_px [$];

    int err_cnt      = 0;
    int pixels_sent  = 0;
    int lines_sent   = 0;
    int results_seen = 0;
    int radius_lo    = RADIUS_MAX_DEF;
    int radius_hi    = 0;
    int cycle_cnt    = 0;

    int idle_max    = 0;
    int stall_max   = 0;
    int hold_req    = 0;
    int hold_ack    = 0;

    string ch_names [CH_N] = '{"blue", "green", "red", "alpha"};

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        err_cnt++;
        $display("MISMATCH at cycle %0d: %s", cycle_cnt, what);
    endtask

    // truncated mean of one window, line positions clamped to the line ends
    function automatic t_blur_res window_mean(input int center, input int r, input logic done);
        t_blur_res   res;
        int unsigned sum [CH_N];
        int          k;
        int          idx;
        int          ch;
        for (ch = 0; ch < CH_N; ch++) sum[ch] = 0;
        for (k = center - r; k <= center + r; k++) begin
            idx = k < 0 ? 0 : (k > line_px.size() - 1 ? line_px.size() - 1 : k);
            for (ch = 0; ch < CH_N; ch++) sum[ch] += line_px[idx][ch];
        end
        for (ch = 0; ch < CH_N; ch++) res.px[ch] = 8'(sum[ch] / (2 * r + 1));
        res.done = done;
        return res;
    endfunction

    // accepted pixel: latch radius on a new line, emit ready results, flush on last
    task automatic blur_take_pixel(input t_pix_item item);
        int n;
        int c;
        int cmax;
        if (line_px.size() == 0) begin
            line_r = radius_shadow > RADIUS_MAX_DEF ? RADIUS_MAX_DEF : radius_shadow;
            if (line_r < radius_lo) radius_lo = line_r;
            if (line_r > radius_hi) radius_hi = line_r;
        end
        line_px.push_back(item.px);
        n = line_px.size();
        if (n >= line_r + 1)
            pending_blurs.push_back(window_mean(n - 1 - line_r, line_r,
                                                item.last && line_r == 0));
        if (item.last) begin
            cmax = line_r - 1 < n - 1 ? line_r - 1 : n - 1;
            for (c = cmax; c >= 0; c--)
                pending_blurs.push_back(window_mean(n - 1 - c, line_r, c == 0));
            line_px.delete();
            lines_sent++;
        end
    endtask

    // pixel driver: one transfer per valid/ready edge, random gap after each pixel
    t_pix_item cur_item;
    int        gap_left = 0;

    always @(posedge clk) begin
        if (!rst_n) begin
            pix_if.valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (pix_if.valid && pix_if.ready) begin
                blur_take_pixel(cur_item);
                pixels_sent++;
            end
            if (!pix_if.valid || pix_if.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    pix_if.valid <= 1'b0;
                end else if (pix_backlog.size() != 0) begin
                    cur_item = pix_backlog.pop_front();
                    pix_if.alpha_in <= cur_item.px[CH_ALPHA];
                    pix_if.red_in   <= cur_item.px[CH_RED];
                    pix_if.green_in <= cur_item.px[CH_GREEN];
                    pix_if.blue_in  <= cur_item.px[CH_BLUE];
                    pix_if.line_end <= cur_item.last;
                    pix_if.valid    <= 1'b1;
                    gap_left = $urandom_range(idle_max, 0);
                end else begin
                    pix_if.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor: random stalls, plus a long hold when requested
    int stall_left = 0;
    int hold_left  = 0;

    always @(posedge clk) begin
        t_blur_res got;
        t_blur_res want;
        int        ch;
        if (!rst_n) begin
            res_if.ready <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                got.px[CH_ALPHA] = res_if.alpha_out;
                got.px[CH_RED]   = res_if.red_out;
                got.px[CH_GREEN] = res_if.green_out;
                got.px[CH_BLUE]  = res_if.blue_out;
                got.done         = res_if.line_done;
                results_seen++;
                if (pending_blurs.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with none expected",
                                              results_seen));
                end else begin
                    want = pending_blurs.pop_front();
                    for (ch = 0; ch < CH_N; ch++)
                        if (got.px[ch] !== want.px[ch])
                            report_mismatch($sformatf("result %0d %s: got %0h want %0h",
                                results_seen, ch_names[ch], got.px[ch], want.px[ch]));
                    if (got.done !== want.done)
                        report_mismatch($sformatf("result %0d line_done: got %b want %b",
                                                  results_seen, got.done, want.done));
                end
                stall_left = $urandom_range(stall_max, 0);
            end else if (stall_left > 0) begin
                stall_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
            end else if (hold_req != hold_ack) begin
                hold_ack  = hold_req;
                hold_left = HOLD_CYCLES;
            end
            res_if.ready <= (stall_left == 0) && (hold_left == 0);
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, pending_blurs.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic queue_pixel(input logic [7:0] a, input logic [7:0] r,
                               input logic [7:0] g, input logic [7:0] b, input logic last);
        t_pix_item item;
        item.px[CH_ALPHA] = a;
        item.px[CH_RED]   = r;
        item.px[CH_GREEN] = g;
        item.px[CH_BLUE]  = b;
        item.last         = last;
        pix_backlog.push_back(item);
    endtask

    // random channel value, biased toward the extremes a quarter of the time
    function automatic logic [7:0] rand_chan();
        if ($urandom_range(3, 0) == 0) return $urandom_range(1, 0) ? 8'hFF : 8'h00;
        return 8'($urandom);
    endfunction

    task automatic queue_random_line(input int len);
        int i;
        for (i = 0; i < len; i++)
            queue_pixel(rand_chan(), rand_chan(), rand_chan(), rand_chan(), i == len - 1);
    endtask

    task automatic wait_drained();
        while (pix_backlog.size() != 0 || pix_if.valid || pending_blurs.size() != 0)
            @(posedge clk);
    endtask

    // radius write only with the block quiet: all results in, then a settle pause
    task automatic set_radius(input logic [RADIUS_W-1:0] r);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we     <= 1'b1;
        cfg_radius <= r;
        @(posedge clk);
        cfg_we <= 1'b0;
        radius_shadow = r;
    endtask

    // stimulus
    initial begin
        int r;
        int phase;
        int nlines;
        int li;
        int len;
        int random_px;

        pix_if.valid    = 1'b0;
        pix_if.alpha_in = '0;
        pix_if.red_in   = '0;
        pix_if.green_in = '0;
        pix_if.blue_in  = '0;
        pix_if.line_end = 1'b0;
        res_if.ready    = 1'b0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset radius: single-pixel line, then alternating extremes
        queue_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        queue_pixel(8'h00, 8'hFF, 8'h00, 8'hFF, 1'b0);
        queue_pixel(8'hFF, 8'h00, 8'hFF, 8'h00, 1'b0);
        queue_pixel(8'h80, 8'h7F, 8'h01, 8'hFE, 1'b1);

        // radius zero passes pixels through
        set_radius(6'd0);
        queue_pixel(8'h5A, 8'hA5, 8'h3C, 8'hC3, 1'b0);
        queue_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        queue_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);

        // largest radius: lines much shorter than the window, full-scale sums
        set_radius(6'd63);
        queue_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        queue_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        queue_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        queue_pixel(8'h00, 8'h01, 8'h02, 8'h03, 1'b1);
        queue_pixel(8'h12, 8'h34, 8'h56, 8'h78, 1'b1);

        // radius written mid-line applies only from the next line
        set_radius(6'd2);
        queue_pixel(8'h10, 8'h20, 8'h30, 8'h40, 1'b0);
        set_radius(6'd5);
        queue_random_line(4);
        queue_random_line(3);

        // random lines over a series of radius settings
        phase     = 0;
        random_px = 0;
        while (random_px < RANDOM_ITEMS) begin
            case ($urandom_range(3, 0))
                0:       r = $urandom_range(2, 0);
                1:       r = $urandom_range(10, 3);
                2:       r = $urandom_range(62, 11);
                default: r = 63;
            endcase
            if (phase == 2) r = $urandom_range(63, 40);
            set_radius(6'(r));
            idle_max  = $urandom_range(1, 0) ? 7 : 0;
            stall_max = $urandom_range(1, 0) ? 7 : 0;
            nlines = $urandom_range(3, 1);
            for (li = 0; li < nlines; li++) begin
                if (phase == 2 && li == 0) begin
                    len = LONG_LINE;
                end else begin
                    if (phase == 1 && li == 0) len = 24;
                    else if ($urandom_range(7, 0) == 0) len = $urandom_range(30, 16);
                    else len = $urandom_range(12, 1);
                    random_px += len;
                end
                queue_random_line(len);
            end
            // receiver holds off while the driver keeps offering pixels
            if (phase == 1) hold_req++;
            phase++;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d pixels in %0d lines, %0d blurred pixels checked",
                 pixels_sent, lines_sent, results_seen);
        $display("Line radius spanned %0d to %0d, with a mid-line radius write",
                 radius_lo, radius_hi);
        if (err_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", err_cnt);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
`default_nettype wire

FILE: files.f
rtl/bbl_pkg.sv
rtl/bbl_ifs.sv
rtl/bbl_line_store.sv
rtl/bbl_recip_div.sv
rtl/box_blur_line_pass_top.sv
sim/box_blur_line_pass_top_tb.sv
